[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QLSB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QLSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/qlsb_pkg.sv]
// ---------------------------------------------------------------------------
// qlsb_pkg
// Shared constants, types and the sigmoid helper of the Q-learning step.
// ---------------------------------------------------------------------------
package qlsb_pkg;

    // Default sizes of the ring and of the sigmoid table.
    localparam int NUM_STATES_DEF  = 12;
    localparam int SIG_ENTRIES_DEF = 256;

    // Field widths.
    localparam int Q_W     = 20;
    localparam int RATE_W  = 17;
    localparam int ITEMP_W = 16;
    localparam int FST_W   = 4;
    localparam int DRAW_W  = 7;
    localparam int P_W     = 17;

    // One in Q1.16; rates above it saturate.
    localparam logic [RATE_W-1:0] RATE_ONE = 17'd65536;

    // Register reset values.
    localparam logic [RATE_W-1:0]  LEARN_RATE_RST = 17'd6554;
    localparam logic [RATE_W-1:0]  DISCOUNT_RST   = 17'd58982;
    localparam logic [ITEMP_W-1:0] INV_TEMP_RST   = 16'd2560;
    localparam logic [FST_W-1:0]   GOAL_RST       = 4'd0;
    localparam logic [Q_W-1:0]     REWARD_RST     = 20'd65536;

    // Register indexes (word address on the configuration port).
    localparam int REG_W = 3;
    localparam logic [REG_W-1:0] REG_LEARN_RATE = 3'd0;
    localparam logic [REG_W-1:0] REG_DISCOUNT   = 3'd1;
    localparam logic [REG_W-1:0] REG_INV_TEMP   = 3'd2;
    localparam logic [REG_W-1:0] REG_GOAL       = 3'd3;
    localparam logic [REG_W-1:0] REG_REWARD     = 3'd4;

    // Read address selection of the Q memory.
    localparam logic [1:0] RD_IN_S0 = 2'd0;
    localparam logic [1:0] RD_S1    = 2'd1;
    localparam logic [1:0] RD_N0    = 2'd2;
    localparam logic [1:0] RD_N1    = 2'd3;

    typedef struct packed {
        logic [RATE_W-1:0]  learn_rate;
        logic [RATE_W-1:0]  discount;
        logic [ITEMP_W-1:0] inv_temp;
        logic [FST_W-1:0]   goal_state;
        logic [Q_W-1:0]     reward;
    } cfg_t;

    typedef struct packed {
        logic       clear;
        logic       load_in;
        logic [1:0] rd_sel;
        logic       cap_q0;
        logic       do_temp;
        logic       do_index;
        logic       do_select;
        logic       cap_qn0;
        logic       do_disc;
        logic       do_learn;
        logic       do_write;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

    // exp(-y) in Q0.32 for y in Q16, by sixteen squarings of (1 - y/2^16).
    function automatic logic [63:0] sig_exp(input logic [63:0] y);
        logic [63:0] v;
        v = (y == 64'd0) ? 64'h0000_0000_FFFF_FFFF : (64'h0000_0001_0000_0000 - y);
        for (int k = 0; k < 16; k++)
        begin
            v = (v * v) >> 32;
        end
        return v;
    endfunction

endpackage

[sv/q_learning_step_boltzmann.sv]
// ---------------------------------------------------------------------------
// q_learning_step_boltzmann
// One tabular Q-learning step per input word on a ring of NUM_STATES states,
// with two actions picked by a table-based Boltzmann (sigmoid) choice. After
// reset the Q memory is swept to zero, during which s_axis_tready stays low;
// configuration writes are taken at any time. Each word then runs through the
// step states RD_S1 to WRITE before the next word can be accepted, and its
// result is loaded into the output register in WRITE. This schedule is set by
// the Q memory, whose single read port serves four reads per step (both
// actions of the current and of the next state), and by the registered
// multiplier chain that follows. The result register frees the input side: a
// new word is accepted while a result waits, and the step only holds at
// write-back when the previous result is still there.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module q_learning_step_boltzmann #(
    parameter int NUM_STATES      = qlsb_pkg::NUM_STATES_DEF,
    parameter int SIGMOID_ENTRIES = qlsb_pkg::SIG_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [3:0] current_state, [10:4] random_draw

    // Result words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [0] chosen_action, [4:1] next_state,
                                        // [24:5] new_q_value, [25] goal_reached
);

    logic [qlsb_pkg::RATE_W-1:0]  learn_rate_reg;
    logic [qlsb_pkg::RATE_W-1:0]  discount_reg;
    logic [qlsb_pkg::ITEMP_W-1:0] inv_temp_reg;
    logic [qlsb_pkg::FST_W-1:0]   goal_reg;
    logic [qlsb_pkg::Q_W-1:0]     reward_reg;

    logic [qlsb_pkg::REG_W-1:0]   reg_sel;
    logic                         cfg_write;

    qlsb_pkg::cfg_t               cfg;
    qlsb_pkg::cmd_t               cmd;
    qlsb_pkg::status_t            status;

    logic                         res_action;
    logic [qlsb_pkg::FST_W-1:0]   res_next_state;
    logic [qlsb_pkg::Q_W-1:0]     res_q;
    logic                         res_goal;

    // Register file write and read-back.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= qlsb_pkg::LEARN_RATE_RST;
            discount_reg   <= qlsb_pkg::DISCOUNT_RST;
            inv_temp_reg   <= qlsb_pkg::INV_TEMP_RST;
            goal_reg       <= qlsb_pkg::GOAL_RST;
            reward_reg     <= qlsb_pkg::REWARD_RST;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                qlsb_pkg::REG_LEARN_RATE: learn_rate_reg <= pwdata[16:0];
                qlsb_pkg::REG_DISCOUNT:   discount_reg   <= pwdata[16:0];
                qlsb_pkg::REG_INV_TEMP:   inv_temp_reg   <= pwdata[15:0];
                qlsb_pkg::REG_GOAL:       goal_reg       <= pwdata[3:0];
                qlsb_pkg::REG_REWARD:     reward_reg     <= pwdata[19:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            qlsb_pkg::REG_LEARN_RATE: prdata = 32'(learn_rate_reg);
            qlsb_pkg::REG_DISCOUNT:   prdata = 32'(discount_reg);
            qlsb_pkg::REG_INV_TEMP:   prdata = 32'(inv_temp_reg);
            qlsb_pkg::REG_GOAL:       prdata = 32'(goal_reg);
            qlsb_pkg::REG_REWARD:     prdata = 32'(reward_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.learn_rate = learn_rate_reg;
    assign cfg.discount   = discount_reg;
    assign cfg.inv_temp   = inv_temp_reg;
    assign cfg.goal_state = goal_reg;
    assign cfg.reward     = reward_reg;

    // Step sequencer.
    qlsb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and Q memory.
    qlsb_datapath #(
        .NUM_STATES      (NUM_STATES),
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .in_state       (s_axis_tdata[3:0]),
        .in_draw        (s_axis_tdata[10:4]),
        .status         (status),
        .res_action     (res_action),
        .res_next_state (res_next_state),
        .res_q          (res_q),
        .res_goal       (res_goal)
    );

    // Result word packing.
    assign m_axis_tdata = {6'b000000, res_goal, res_q, res_next_state, res_action};

    // A step in progress blocks further input words.
    `QLSB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted during a step")

    // A result never appears in the cycle right after its input word.
    `QLSB_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared too early")

    // A reported next state lies on the ring.
    `QLSB_ASSERT_SAME(a_next_on_ring, m_axis_tvalid, (NUM_STATES > 15) || (m_axis_tdata[4:1] < 4'(NUM_STATES)), "next state off the ring")

endmodule

[sv/qlsb_ctrl.sv]
// ---------------------------------------------------------------------------
// qlsb_ctrl
// Sequencer of the Q-learning step: memory clear, step schedule, result slot.
// ---------------------------------------------------------------------------
module qlsb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  qlsb_pkg::status_t  status,
    output qlsb_pkg::cmd_t     cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_RD_S1  = 4'd2;
    localparam logic [3:0] ST_TEMP   = 4'd3;
    localparam logic [3:0] ST_INDEX  = 4'd4;
    localparam logic [3:0] ST_SELECT = 4'd5;
    localparam logic [3:0] ST_RD_N0  = 4'd6;
    localparam logic [3:0] ST_RD_N1  = 4'd7;
    localparam logic [3:0] ST_DISC   = 4'd8;
    localparam logic [3:0] ST_LEARN  = 4'd9;
    localparam logic [3:0] ST_WRITE  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // The result slot is free when empty or being emptied this cycle.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Commands decoded from the state.
    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = qlsb_pkg::RD_IN_S0;
        case (state_reg)
            ST_CLEAR:  cmd.clear = 1'b1;
            ST_IDLE:   cmd.load_in = in_valid;
            ST_RD_S1:
            begin
                cmd.rd_sel = qlsb_pkg::RD_S1;
                cmd.cap_q0 = 1'b1;
            end
            ST_TEMP:   cmd.do_temp = 1'b1;
            ST_INDEX:  cmd.do_index = 1'b1;
            ST_SELECT: cmd.do_select = 1'b1;
            ST_RD_N0:  cmd.rd_sel = qlsb_pkg::RD_N0;
            ST_RD_N1:
            begin
                cmd.rd_sel  = qlsb_pkg::RD_N1;
                cmd.cap_qn0 = 1'b1;
            end
            ST_DISC:   cmd.do_disc = 1'b1;
            ST_LEARN:  cmd.do_learn = 1'b1;
            ST_WRITE:  cmd.do_write = slot_free;
            default:   cmd.rd_sel = qlsb_pkg::RD_IN_S0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (status.clear_last) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_RD_S1;
            ST_RD_S1:  state_next = ST_TEMP;
            ST_TEMP:   state_next = ST_INDEX;
            ST_INDEX:  state_next = ST_SELECT;
            ST_SELECT: state_next = ST_RD_N0;
            ST_RD_N0:  state_next = ST_RD_N1;
            ST_RD_N1:  state_next = ST_DISC;
            ST_DISC:   state_next = ST_LEARN;
            ST_LEARN:  state_next = ST_WRITE;
            ST_WRITE:  if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Result slot valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.do_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/qlsb_datapath.sv]
// ---------------------------------------------------------------------------
// qlsb_datapath
// Q memory, sigmoid table, multipliers and result word of the learning step.
// ---------------------------------------------------------------------------
module qlsb_datapath #(
    parameter int NUM_STATES      = qlsb_pkg::NUM_STATES_DEF,
    parameter int SIGMOID_ENTRIES = qlsb_pkg::SIG_ENTRIES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  qlsb_pkg::cmd_t                    cmd,
    input  qlsb_pkg::cfg_t                    cfg,
    input  logic [qlsb_pkg::FST_W-1:0]        in_state,
    input  logic [qlsb_pkg::DRAW_W-1:0]       in_draw,
    output qlsb_pkg::status_t                 status,
    output logic                              res_action,
    output logic [qlsb_pkg::FST_W-1:0]        res_next_state,
    output logic [qlsb_pkg::Q_W-1:0]          res_q,
    output logic                              res_goal
);

    localparam int SW    = $clog2(NUM_STATES);
    localparam int AW    = SW + 1;
    localparam int DEPTH = 2 * NUM_STATES;
    localparam int IW    = $clog2(SIGMOID_ENTRIES);
    localparam int CW    = (SW > qlsb_pkg::FST_W) ? SW : qlsb_pkg::FST_W;
    localparam int TW    = 38 + IW;
    localparam int UW    = TW - 28;
    localparam int QW    = qlsb_pkg::Q_W;
    localparam int PW    = qlsb_pkg::P_W;

    // Constant tables: input state modulo ring size, and the sigmoid curve.
    logic [SW-1:0] mod_rom [16];
    logic [PW-1:0] sig_rom [SIGMOID_ENTRIES];

    for (genvar g = 0; g < 16; g++)
    begin : g_mod
        localparam int ModV = g % NUM_STATES;
        assign mod_rom[g] = SW'(ModV);
    end

    // Each entry is the sigmoid at the center of its cell, x in [-8, 8).
    for (genvar g = 0; g < SIGMOID_ENTRIES; g++)
    begin : g_sig
        localparam longint CellNum =
            (longint'(2 * g + 1) * longint'(524288)) / longint'(SIGMOID_ENTRIES);
        localparam longint Xc = CellNum - longint'(524288);
        localparam logic [63:0] Ymag = (Xc < 0) ? 64'(-Xc) : 64'(Xc);
        localparam logic [63:0] Ev = qlsb_pkg::sig_exp(Ymag);
        localparam logic [63:0] Den = 64'h0000_0001_0000_0000 + Ev;
        localparam logic [63:0] Ent = (Xc >= 0) ?
            (64'h0001_0000_0000_0000 / Den) : ((Ev << 16) / Den);
        assign sig_rom[g] = Ent[PW-1:0];
    end

    // Q memory, one write and one registered read per cycle.
    logic [QW-1:0] q_mem [DEPTH];
    logic [QW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [QW-1:0] wr_data;
    logic          wr_en;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    // Step registers.
    logic [SW-1:0]              s_reg;
    logic [qlsb_pkg::DRAW_W-1:0] draw_reg;
    logic [QW-1:0]              q0_reg;
    logic [QW-1:0]              q1_reg;
    logic [QW-1:0]              qn0_reg;
    logic signed [37:0]         prod_reg;
    logic signed [37:0]         prod_next;
    logic [IW-1:0]              idx_reg;
    logic [IW-1:0]              idx_next;
    logic                       act_reg;
    logic                       act_next;
    logic [SW-1:0]              nxt_reg;
    logic [SW-1:0]              nxt_next;
    logic                       goal_reg;
    logic                       goal_next;
    logic [36:0]                gprod_reg;
    logic [36:0]                gprod_next;
    logic signed [40:0]         pr_reg;
    logic signed [40:0]         pr_next;

    // Result word.
    logic                       res_action_reg;
    logic [qlsb_pkg::FST_W-1:0] res_next_state_reg;
    logic [QW-1:0]              res_q_reg;
    logic                       res_goal_reg;

    // Intermediate values.
    logic [qlsb_pkg::RATE_W-1:0] learn_sat;
    logic [qlsb_pkg::RATE_W-1:0] disc_sat;
    logic signed [20:0]          temp_diff;
    logic signed [37:0]          t_val;
    logic [TW-1:0]               t_scaled;
    logic [UW-1:0]               t_cell;
    logic [PW-1:0]               p0;
    logic [23:0]                 draw_scaled;
    logic [23:0]                 p0_scaled;
    logic [SW-1:0]               s_dec;
    logic [SW-1:0]               s_inc;
    logic [QW-1:0]               qmax;
    logic [QW-1:0]               reward_sel;
    logic [21:0]                 target;
    logic [QW-1:0]               qold;
    logic signed [22:0]          learn_diff;
    logic signed [24:0]          dq;
    logic signed [25:0]          nq_wide;
    logic [QW-1:0]               nq_sat;

    // Rates above one saturate to one.
    assign learn_sat = (cfg.learn_rate > qlsb_pkg::RATE_ONE) ? qlsb_pkg::RATE_ONE
                                                             : cfg.learn_rate;
    assign disc_sat  = (cfg.discount > qlsb_pkg::RATE_ONE) ? qlsb_pkg::RATE_ONE
                                                           : cfg.discount;

    // Read address selection.
    always_comb
    begin
        case (cmd.rd_sel)
            qlsb_pkg::RD_IN_S0: rd_addr = {mod_rom[in_state], 1'b0};
            qlsb_pkg::RD_S1:    rd_addr = {s_reg, 1'b1};
            qlsb_pkg::RD_N0:    rd_addr = {nxt_reg, 1'b0};
            qlsb_pkg::RD_N1:    rd_addr = {nxt_reg, 1'b1};
            default:            rd_addr = {mod_rom[in_state], 1'b0};
        endcase
    end

    // Write port: the clearing sweep after reset, then step write-back.
    assign wr_en   = cmd.clear || cmd.do_write;
    assign wr_addr = cmd.clear ? clr_addr_reg : {s_reg, act_reg};
    assign wr_data = cmd.clear ? '0 : nq_sat;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= q_mem[rd_addr];
    end

    // Clearing sweep counter.
    assign clr_addr_next     = cmd.clear ? (clr_addr_reg + AW'(1)) : clr_addr_reg;
    assign status.clear_last = (clr_addr_reg == AW'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Preference term (q0 - q1) times inverse temperature, Q.24.
    assign temp_diff = $signed({1'b0, q0_reg}) - $signed({1'b0, rd_data_reg});
    assign prod_next = 38'(temp_diff) * 38'($signed({1'b0, cfg.inv_temp}));

    // Table index: shift x by +8, scale to cells, saturate at both ends.
    assign t_val    = prod_reg + 38'sd134217728;
    assign t_scaled = TW'(t_val[36:0]) * TW'(SIGMOID_ENTRIES);
    assign t_cell   = t_scaled[TW-1:28];
    assign idx_next = t_val[37] ? '0 :
                      ((t_cell >= UW'(SIGMOID_ENTRIES)) ? IW'(SIGMOID_ENTRIES - 1)
                                                        : t_cell[IW-1:0]);

    // Action choice and move on the ring.
    assign p0          = sig_rom[idx_reg];
    assign draw_scaled = {1'b0, draw_reg, 16'h0000};
    assign p0_scaled   = 24'(p0) * 24'd100;
    assign act_next    = !(draw_scaled < p0_scaled);
    assign s_dec       = (s_reg == '0) ? SW'(NUM_STATES - 1) : (s_reg - SW'(1));
    assign s_inc       = (s_reg == SW'(NUM_STATES - 1)) ? '0 : (s_reg + SW'(1));
    assign nxt_next    = act_next ? s_inc : s_dec;

    // Discounted best value of the next state.
    assign qmax       = (rd_data_reg > qn0_reg) ? rd_data_reg : qn0_reg;
    assign gprod_next = 37'(disc_sat) * 37'(qmax);
    assign goal_next  = (CW'(nxt_reg) == CW'(cfg.goal_state));

    // Weighted correction toward the target.
    assign reward_sel = goal_reg ? cfg.reward : '0;
    assign target     = 22'(reward_sel) + 22'(gprod_reg[36:16]);
    assign qold       = act_reg ? q1_reg : q0_reg;
    assign learn_diff = $signed({1'b0, target}) - $signed({3'b000, qold});
    assign pr_next    = 41'(learn_diff) * 41'($signed({1'b0, learn_sat}));

    // Floor division by 2^16, add and saturate to the Q4.16 range.
    assign dq      = pr_reg[40:16];
    assign nq_wide = $signed({6'b000000, qold}) + 26'(dq);
    assign nq_sat  = nq_wide[25] ? '0 :
                     ((nq_wide > 26'sd1048575) ? {QW{1'b1}} : nq_wide[QW-1:0]);

    // Step registers, loaded by the commands of the step schedule.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            s_reg    <= mod_rom[in_state];
            draw_reg <= in_draw;
        end
        if (cmd.cap_q0)
        begin
            q0_reg <= rd_data_reg;
        end
        if (cmd.do_temp)
        begin
            q1_reg   <= rd_data_reg;
            prod_reg <= prod_next;
        end
        if (cmd.do_index)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.do_select)
        begin
            act_reg <= act_next;
            nxt_reg <= nxt_next;
        end
        if (cmd.cap_qn0)
        begin
            qn0_reg <= rd_data_reg;
        end
        if (cmd.do_disc)
        begin
            gprod_reg <= gprod_next;
            goal_reg  <= goal_next;
        end
        if (cmd.do_learn)
        begin
            pr_reg <= pr_next;
        end
        if (cmd.do_write)
        begin
            res_action_reg     <= act_reg;
            res_next_state_reg <= qlsb_pkg::FST_W'(nxt_reg);
            res_q_reg          <= nq_sat;
            res_goal_reg       <= goal_reg;
        end
    end

    assign res_action     = res_action_reg;
    assign res_next_state = res_next_state_reg;
    assign res_q          = res_q_reg;
    assign res_goal       = res_goal_reg;

endmodule
